// ===== sv/mvm_pkg.sv =====
package mvm_pkg;

    localparam int MAX_DIM = 256;
    localparam int ADDR_W  = $clog2(MAX_DIM);
    localparam int DIM_W   = 9;
    localparam int VALUE_W = 16;
    localparam int PROD_W  = 2 * VALUE_W;
    localparam int SUM_W   = 40;
    localparam int ROW_W   = 8;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [DIM_W-1:0]         t_dim;
    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [SUM_W-1:0]   t_sum;

    function automatic t_dim eff_dim(input t_dim dim);
        t_dim d;
        d = dim;
        if (dim == '0) begin
            d = t_dim'(1);
        end else if (dim > t_dim'(MAX_DIM)) begin
            d = t_dim'(MAX_DIM);
        end
        return d;
    endfunction

    function automatic logic is_last(input t_addr pos, input t_dim dim);
        return ((t_dim'(pos) + t_dim'(1)) >= dim);
    endfunction

endpackage

// ===== sv/mvm_ram.sv =====
module mvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/matrix_vector_multiply.sv =====
// Pipeline: stage 1, stage 2 and output registers; a row's sum is output after its last element.
// Throughput: one request per cycle while the output is not stalled, vector loads and
// matrix elements alike, set by the single value input and the multiply-accumulate pipeline.
// Output stall freezes the whole pipeline.
// Reset: dimension 256, positions and accumulator zero; the vector store
// keeps whatever it holds and needs no clearing pass.
module matrix_vector_multiply
    import mvm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [DIM_W-1:0]        i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_mode,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [SUM_W-1:0] o_row_sum,
    output logic [ROW_W-1:0]        o_row_number,
    output logic                    o_last_row
);

    t_dim  r_dim;
    t_addr r_vec_pos, n_vec_pos;
    t_addr r_col_pos, n_col_pos;
    t_addr r_row_pos, n_row_pos;
    t_sum  r_acc, n_acc;

    logic   r_s1_valid, r_s1_last_col, r_s1_last_row;
    t_addr  r_s1_row;
    t_value r_s1_value;

    logic   r_s2_valid, r_s2_last_col, r_s2_last_row;
    t_addr  r_s2_row;
    t_prod  r_s2_prod;

    logic             r_out_valid;
    t_sum             r_out_sum;
    logic [ROW_W-1:0] r_out_row;
    logic             r_out_last;

    t_dim   dim;
    logic   advance, accept, vec_load, mat_elem;
    logic   col_last, row_last;
    t_value ram_q;
    t_prod  prod;
    t_sum   acc_sum;

    assign dim      = eff_dim(r_dim);
    assign advance  = !r_out_valid || !i_stall;
    assign o_stall  = !advance;
    assign accept   = i_valid && advance;
    assign vec_load = accept && !i_mode;
    assign mat_elem = accept && i_mode;
    assign col_last = is_last(r_col_pos, dim);
    assign row_last = is_last(r_row_pos, dim);

    mvm_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(MAX_DIM)
    ) u_vec_store (
        .i_clk  (i_clk),
        .i_we   (vec_load),
        .i_waddr(r_vec_pos),
        .i_wdata(i_value),
        .i_re   (mat_elem),
        .i_raddr(r_col_pos),
        .o_rdata(ram_q)
    );

    assign prod    = t_prod'(r_s1_value) * t_prod'(ram_q);
    assign acc_sum = r_acc + {{(SUM_W-PROD_W){r_s2_prod[PROD_W-1]}}, r_s2_prod};

    always_comb begin
        n_vec_pos = r_vec_pos;
        n_col_pos = r_col_pos;
        n_row_pos = r_row_pos;
        n_acc     = r_acc;
        if (vec_load) begin
            n_vec_pos = is_last(r_vec_pos, dim) ? '0 : r_vec_pos + t_addr'(1);
        end
        if (mat_elem) begin
            n_col_pos = col_last ? '0 : r_col_pos + t_addr'(1);
            if (col_last) begin
                n_row_pos = row_last ? '0 : r_row_pos + t_addr'(1);
            end
        end
        if (advance && r_s2_valid) begin
            n_acc = r_s2_last_col ? '0 : acc_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim       <= DIM_RESET;
            r_vec_pos   <= '0;
            r_col_pos   <= '0;
            r_row_pos   <= '0;
            r_acc       <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dim     <= i_cfg_data;
                r_vec_pos <= '0;
                r_col_pos <= '0;
                r_row_pos <= '0;
                r_acc     <= '0;
            end else begin
                r_vec_pos <= n_vec_pos;
                r_col_pos <= n_col_pos;
                r_row_pos <= n_row_pos;
                r_acc     <= n_acc;
            end
            if (advance) begin
                r_s1_valid  <= mat_elem;
                r_s2_valid  <= r_s1_valid;
                r_out_valid <= r_s2_valid && r_s2_last_col;
            end
        end
    end

    // Advance payload with the pipeline; hold while stalled
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_value    <= i_value;
            r_s1_last_col <= col_last;
            r_s1_last_row <= row_last;
            r_s1_row      <= r_row_pos;
            r_s2_prod     <= prod;
            r_s2_last_col <= r_s1_last_col;
            r_s2_last_row <= r_s1_last_row;
            r_s2_row      <= r_s1_row;
            if (r_s2_valid && r_s2_last_col) begin
                r_out_sum  <= acc_sum;
                r_out_row  <= ROW_W'(r_s2_row);
                r_out_last <= r_s2_last_row;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_row_sum    = r_out_sum;
    assign o_row_number = r_out_row;
    assign o_last_row   = r_out_last;

endmodule
